// ===== hw/rtl/hhbw_pkg.sv =====
// hhbw_pkg: shared types, constants and the field sequence of the header writer
// used by hhbw_ctrl, hhbw_datapath and the top level h264_header_bitstream_writer_unit
package hhbw_pkg;

  localparam logic [7:0] NAL_SPS      = 8'h67;
  localparam logic [7:0] NAL_PPS      = 8'h68;
  localparam logic [7:0] NAL_IDR      = 8'h25;
  localparam logic [7:0] NAL_P        = 8'h21;
  localparam logic [7:0] PROFILE_BASE = 8'h42;
  localparam logic [7:0] CONSTR_FLAGS = 8'hC0;
  localparam logic [7:0] LEVEL_30     = 8'h1e;
  localparam logic [7:0] SLICE_TYPE_I = 8'd2;
  localparam logic [7:0] SLICE_TYPE_P = 8'd5;
  localparam logic [5:0] QP_BASE      = 6'd26;

  localparam int ACC_W   = 48;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 13;
  localparam int STEP_W  = 5;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_QUANT_PARAM  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    SRC_BITS   = 3'd0,
    SRC_UE_LIT = 3'd1,
    SRC_UE_FNB = 3'd2,
    SRC_UE_WMB = 3'd3,
    SRC_UE_HMB = 3'd4,
    SRC_SE_DQ  = 3'd5,
    SRC_UE_IDR = 3'd6,
    SRC_FNUM   = 3'd7
  } fld_src_e;

  typedef struct packed {
    fld_src_e    src;
    logic        align;
    logic [7:0]  lit;
    logic [4:0]  len;
    logic        fin;
  } fld_t;

  typedef struct packed {
    logic load;
    logic push_req;
    logic drain;
    fld_t fld;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic is_i;
    logic push_taken;
    logic last_pop;
  } sts_t;

  function automatic fld_t mk_fld(input fld_src_e src, input logic align,
                                  input logic [7:0] lit, input logic [4:0] len,
                                  input logic fin);
    fld_t f;
    f.src   = src;
    f.align = align;
    f.lit   = lit;
    f.len   = len;
    f.fin   = fin;
    return f;
  endfunction

  // one header field per step
  function automatic fld_t seq_field(input logic mode, input logic is_i,
                                     input logic [STEP_W-1:0] step);
    fld_t f;
    f = mk_fld(SRC_BITS, 1'b0, 8'h00, 5'd0, 1'b0);
    if (!mode) begin
      case (step)
        5'd0, 5'd17:  f = mk_fld(SRC_BITS, 1'b0, 8'h00, 5'd24, 1'b0);
        5'd1, 5'd18:  f = mk_fld(SRC_BITS, 1'b0, 8'h01, 5'd8, 1'b0);
        5'd2:         f = mk_fld(SRC_BITS, 1'b0, NAL_SPS, 5'd8, 1'b0);
        5'd3:         f = mk_fld(SRC_BITS, 1'b0, PROFILE_BASE, 5'd8, 1'b0);
        5'd4:         f = mk_fld(SRC_BITS, 1'b0, CONSTR_FLAGS, 5'd8, 1'b0);
        5'd5:         f = mk_fld(SRC_BITS, 1'b0, LEVEL_30, 5'd8, 1'b0);
        5'd7, 5'd9:   f = mk_fld(SRC_UE_FNB, 1'b0, 8'h00, 5'd0, 1'b0);
        5'd10:        f = mk_fld(SRC_UE_LIT, 1'b0, 8'h01, 5'd0, 1'b0);
        5'd11:        f = mk_fld(SRC_BITS, 1'b0, 8'h00, 5'd1, 1'b0);
        5'd12:        f = mk_fld(SRC_UE_WMB, 1'b0, 8'h00, 5'd0, 1'b0);
        5'd13:        f = mk_fld(SRC_UE_HMB, 1'b0, 8'h00, 5'd0, 1'b0);
        5'd14:        f = mk_fld(SRC_BITS, 1'b0, 8'h01, 5'd1, 1'b0);
        5'd15, 5'd26, 5'd30:
                      f = mk_fld(SRC_BITS, 1'b0, 8'h00, 5'd3, 1'b0);
        5'd16:        f = mk_fld(SRC_BITS, 1'b1, 8'h00, 5'd0, 1'b0);
        5'd19:        f = mk_fld(SRC_BITS, 1'b0, NAL_PPS, 5'd8, 1'b0);
        5'd22:        f = mk_fld(SRC_BITS, 1'b0, 8'h00, 5'd2, 1'b0);
        5'd27, 5'd28: f = mk_fld(SRC_SE_DQ, 1'b0, 8'h00, 5'd0, 1'b0);
        5'd31:        f = mk_fld(SRC_BITS, 1'b1, 8'h00, 5'd0, 1'b1);
        default:      f = mk_fld(SRC_UE_LIT, 1'b0, 8'h00, 5'd0, 1'b0);
      endcase
    end else begin
      case (step)
        5'd0:    f = mk_fld(SRC_BITS, 1'b0, 8'h00, 5'd24, 1'b0);
        5'd1:    f = mk_fld(SRC_BITS, 1'b0, 8'h01, 5'd8, 1'b0);
        5'd2:    f = mk_fld(SRC_BITS, 1'b0, is_i ? NAL_IDR : NAL_P, 5'd8, 1'b0);
        5'd4:    f = mk_fld(SRC_UE_LIT, 1'b0, is_i ? SLICE_TYPE_I : SLICE_TYPE_P,
                            5'd0, 1'b0);
        5'd6, 5'd8:
                 f = mk_fld(SRC_FNUM, 1'b0, 8'h00, 5'd0, 1'b0);
        5'd7:    f = is_i ? mk_fld(SRC_UE_IDR, 1'b0, 8'h00, 5'd0, 1'b0)
                          : mk_fld(SRC_BITS, 1'b0, 8'h00, 5'd0, 1'b0);
        5'd9:    f = mk_fld(SRC_BITS, 1'b0, 8'h00, is_i ? 5'd2 : 5'd3, 1'b0);
        5'd10:   f = mk_fld(SRC_UE_LIT, 1'b0, 8'h00, 5'd0, 1'b1);
        default: f = mk_fld(SRC_UE_LIT, 1'b0, 8'h00, 5'd0, 1'b0);
      endcase
    end
    return f;
  endfunction

endpackage

// ===== hw/rtl/hhbw_ctrl.sv =====
// hhbw_ctrl: sequencer that walks the header fields and issues one push a cycle while pushes are taken
// depends on hhbw_pkg
module hhbw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  hhbw_pkg::sts_t sts,
  output hhbw_pkg::cmd_t cmd
);
  import hhbw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EMIT  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
          step_next  = '0;
        end
      end
      ST_EMIT: begin
        cmd.push_req = 1'b1;
        cmd.fld      = seq_field(sts.mode, sts.is_i, step);
        if (sts.push_taken) begin
          step_next = step + 1'b1;
          if (cmd.fld.fin) state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        if (sts.last_pop) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== hw/rtl/hhbw_datapath.sv =====
// hhbw_datapath: config registers, exp-golomb coder, bit packer and output register
// depends on hhbw_pkg; driven by hhbw_ctrl
module hhbw_datapath #(
  parameter int FRAME_NUM_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [hhbw_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          mode,
  input  logic [15:0]                   idr_id,
  input  logic [7:0]                    gop_frame_index,
  input  hhbw_pkg::cmd_t                cmd,
  output hhbw_pkg::sts_t                sts,
  output logic                          hdr_valid,
  input  logic                          hdr_ready,
  output logic [7:0]                    data_byte,
  output logic                          last,
  output logic [7:0]                    leftover_byte,
  output logic [2:0]                    leftover_count
);
  import hhbw_pkg::*;

  localparam logic [15:0] FNUM_MASK = 16'((32'd1 << FRAME_NUM_BITS) - 1);

  logic [CFG_W-1:0]  frame_width, frame_height;
  logic [5:0]        quant_param;
  logic              mode_q;
  logic [15:0]       idr_q;
  logic [7:0]        gop_q;
  logic [ACC_W-1:0]  acc, acc_next, acc_shift;
  logic [CNT_W-1:0]  cnt, cnt_next, cnt_pop;

  logic [8:0]        wmb, hmb;
  logic [6:0]        dq_mag;
  logic [15:0]       ue_arg;
  logic [16:0]       ue_x;
  logic [4:0]        ue_n;
  logic [32:0]       fval;
  logic [CNT_W-1:0]  flen;
  logic [3:0]        alen;
  logic [6:0]        sh;
  logic              out_free, pop, push, last_pop;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(720);
      frame_height <= CFG_W'(576);
      quant_param  <= QP_BASE;
    end else if (cfg_we) begin
      case (reg_idx_e'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_QUANT_PARAM:  quant_param  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      idr_q  <= idr_id;
      gop_q  <= gop_frame_index;
    end
  end

  // size in macroblocks minus one, small pictures count as one
  assign wmb = (frame_width[12:4] == '0) ? 9'd0 : frame_width[12:4] - 9'd1;
  assign hmb = (frame_height[12:4] == '0) ? 9'd0 : frame_height[12:4] - 9'd1;

  // signed qp offset mapped to code number, or the ue argument that the field's source selects
  always_comb begin
    if (quant_param <= QP_BASE) begin
      dq_mag = {1'b0, QP_BASE} - {1'b0, quant_param};
      ue_arg = 16'({dq_mag, 1'b0});
    end else begin
      dq_mag = {1'b0, quant_param} - {1'b0, QP_BASE};
      ue_arg = 16'({dq_mag, 1'b0}) - 16'd1;
    end
    case (cmd.fld.src)
      SRC_UE_LIT: ue_arg = 16'(cmd.fld.lit);
      SRC_UE_FNB: ue_arg = 16'(FRAME_NUM_BITS - 4);
      SRC_UE_WMB: ue_arg = 16'(wmb);
      SRC_UE_HMB: ue_arg = 16'(hmb);
      SRC_UE_IDR: ue_arg = idr_q;
      default: ;
    endcase
  end

  assign ue_x = 17'(ue_arg) + 17'd1;

  always_comb begin
    ue_n = '0;
    for (int i = 1; i < 17; i++) begin
      if (ue_x[i]) ue_n = 5'(i);
    end
  end

  // pop a byte only while more bits are sure to follow, or when draining
  assign out_free = !hdr_valid || hdr_ready;
  assign pop      = out_free && (cmd.drain ? (cnt >= CNT_W'(8)) : (cnt >= CNT_W'(16)));
  assign last_pop = pop && cmd.drain && (cnt < CNT_W'(16));
  assign cnt_pop  = pop ? cnt - CNT_W'(8) : cnt;
  assign acc_shift = pop ? {acc[ACC_W-9:0], 8'h00} : acc;
  assign push     = cmd.push_req && (cnt_pop < CNT_W'(16));
  assign alen     = 4'd8 - {1'b0, cnt_pop[2:0]};

  always_comb begin
    if (cmd.fld.align) begin
      flen = CNT_W'(alen);
      fval = 33'd1 << (alen - 4'd1);
    end else begin
      case (cmd.fld.src)
        SRC_BITS: begin
          flen = CNT_W'(cmd.fld.len);
          fval = 33'(cmd.fld.lit);
        end
        SRC_FNUM: begin
          flen = CNT_W'(FRAME_NUM_BITS);
          fval = 33'({8'h00, gop_q} & FNUM_MASK);
        end
        default: begin
          flen = CNT_W'({ue_n, 1'b1});
          fval = 33'(ue_x);
        end
      endcase
    end
  end

  assign sh = 7'(ACC_W) - 7'(cnt_pop) - 7'(flen);

  always_comb begin
    acc_next = acc_shift;
    cnt_next = cnt_pop;
    if (push) begin
      acc_next = acc_shift | (ACC_W'(fval) << sh);
      cnt_next = cnt_pop + flen;
    end
    if (cmd.load) begin
      acc_next = '0;
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      acc <= '0;
    end else begin
      cnt <= cnt_next;
      acc <= acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (pop) begin
      hdr_valid <= 1'b1;
    end else if (hdr_ready) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_byte      <= acc[ACC_W-1 -: 8];
      last           <= last_pop;
      leftover_byte  <= last_pop ? acc[ACC_W-9 -: 8] : 8'h00;
      leftover_count <= last_pop ? cnt[2:0] : 3'd0;
    end
  end

  assign sts.mode       = mode_q;
  assign sts.is_i       = (gop_q == 8'h00);
  assign sts.push_taken = push;
  assign sts.last_pop   = last_pop;

endmodule

// ===== hw/rtl/h264_header_bitstream_writer_unit.sv =====
// h264_header_bitstream_writer_unit: top level of the sps/pps and slice header writer
// depends on hhbw_pkg, hhbw_ctrl and hhbw_datapath
//
//   channel   handshake              payload
//   request   req_valid / req_ready  mode, idr_id, gop_frame_index
//   header    hdr_valid / hdr_ready  data_byte, last, leftover_byte, leftover_count
//   config    cfg_we                 cfg_index, cfg_data
//
// a request is taken in idle, then one field per cycle goes through the bit packer while
// the packer has room (32 fields for the stream header, 11 for a slice header), then the
// drain state flushes the packer
// a field waits while 16 or more bits remain after the word of that cycle, and receiver
// stalls hold the output register and keep the packer from popping bytes
// synchronous reset restores the config defaults and returns to idle
module h264_header_bitstream_writer_unit #(
  parameter int FRAME_NUM_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [hhbw_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        mode,
  input  logic [15:0]                 idr_id,
  input  logic [7:0]                  gop_frame_index,
  output logic                        hdr_valid,
  input  logic                        hdr_ready,
  output logic [7:0]                  data_byte,
  output logic                        last,
  output logic [7:0]                  leftover_byte,
  output logic [2:0]                  leftover_count
);
  import hhbw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hhbw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hhbw_datapath #(
    .FRAME_NUM_BITS (FRAME_NUM_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .idr_id          (idr_id),
    .gop_frame_index (gop_frame_index),
    .cmd             (cmd),
    .sts             (sts),
    .hdr_valid       (hdr_valid),
    .hdr_ready       (hdr_ready),
    .data_byte       (data_byte),
    .last            (last),
    .leftover_byte   (leftover_byte),
    .leftover_count  (leftover_count)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a header is in progress");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    sts.last_pop |=> (req_ready && hdr_valid && last))
    else $error("final word not followed by idle");

  a_tail_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (hdr_valid && !last) |-> (leftover_count == 3'd0 && leftover_byte == 8'h00))
    else $error("leftover bits on a word that is not the last");

  a_no_push_while_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.drain |-> !sts.push_taken)
    else $error("field pushed while draining");

endmodule
